### hdl/basis_series_evaluator_defines.svh
// ----------------------------------------------------------------------------
// Basis series evaluator assertion macros
// Concurrent assertion helpers clocked on clk and held off while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef BASIS_SERIES_EVALUATOR_DEFINES_SVH
`define BASIS_SERIES_EVALUATOR_DEFINES_SVH
`ifndef SYNTH
// antecedent implies consequent in the same cycle
`define BSE_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("basis series evaluator: assertion failed");
// antecedent implies consequent in the next cycle
`define BSE_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("basis series evaluator: assertion failed");
`else
`define BSE_ASSERT_SAME(label, ante, cons)
`define BSE_ASSERT_NEXT(label, ante, cons)
`endif
`endif

### hdl/bse_pkg.sv
// ----------------------------------------------------------------------------
// Basis series evaluator package
// Shared constants, sequencer states, result structs and saturation helper.
// ----------------------------------------------------------------------------
package bse_pkg;

	localparam int BSE_MAX_ORDER = 31;

	// 1.0 in Q16.16
	localparam logic signed [31:0] ONE_Q16 = 32'sd65536;
	localparam logic signed [31:0] NEG_ONE_Q16 = -32'sd65536;

	// configuration register indexes
	localparam logic [1:0] CFG_ARG_OFFSET   = 2'd0;
	localparam logic [1:0] CFG_INV_SCALE    = 2'd1;
	localparam logic [1:0] CFG_BASIS_SELECT = 2'd2;

	typedef enum logic [1:0] {
		BASIS_POWER,
		BASIS_POWER_DER,
		BASIS_CHEB,
		BASIS_CHEB_DER
	} basis_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_NORM_MUL,
		ST_NORM_RND,
		ST_SETUP,
		ST_LOOP_MUL,
		ST_LOOP_RND,
		ST_SCALE_MUL,
		ST_SCALE_RND,
		ST_TERM_MUL,
		ST_ACC
	} state_t;

	typedef struct packed {
		logic signed [31:0] val;
		logic               ov;
	} sat32_t;

	// outputs of the shared multiplier
	typedef struct packed {
		sat32_t             rnd;   // Q16.16 product, rounded half up, saturated
		sat32_t             ext;   // exact product, saturated
		logic signed [63:0] full;  // exact product, low 64 bits
	} mul_res_t;

	function automatic sat32_t sat32(input logic signed [64:0] v);
		sat32_t r;
		r.ov  = !((v[64:31] == '0) || (v[64:31] == '1));
		r.val = r.ov ? (v[64] ? 32'sh80000000 : 32'sh7fffffff) : v[31:0];
		return r;
	endfunction

endpackage

### hdl/bse_mul_unit.sv
// ----------------------------------------------------------------------------
// Shared multiplier
// Registered 33x32 signed product with rounded and exact saturated views.
// ----------------------------------------------------------------------------
module bse_mul_unit
	import bse_pkg::*;
(
	input  logic               clk,
	input  logic               load,
	input  logic signed [32:0] op_a,
	input  logic signed [31:0] op_b,
	output mul_res_t           res
);

	logic signed [64:0] prod_s1;
	logic signed [64:0] rnd_sum;
	logic signed [48:0] rnd;

	always_ff @(posedge clk) begin
		if (load) begin
			prod_s1 <= op_a * op_b;
		end
	end

	// round half up, then floor shift by 16
	assign rnd_sum = prod_s1 + 65'sd32768;
	assign rnd     = rnd_sum[64:16];

	assign res.rnd  = sat32({{16{rnd[48]}}, rnd});
	assign res.ext  = sat32(prod_s1);
	assign res.full = prod_s1[63:0];

endmodule

### hdl/bse_accum.sv
// ----------------------------------------------------------------------------
// Series accumulator
// Saturating Q32.32 running sum, sticky overflow and output word register.
// ----------------------------------------------------------------------------
module bse_accum
	import bse_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               add_en,
	input  logic signed [63:0] term,
	input  logic               term_ov,
	input  logic               last,
	output logic               acc_ready,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [63:0] series_sum,
	output logic               overflowed
);

	logic signed [63:0] run_q;
	logic               sticky_q;
	logic               out_valid_q;
	logic signed [63:0] sum_out_q;
	logic               ov_out_q;
	logic signed [64:0] sum;
	logic               sum_ov;
	logic signed [63:0] sum_sat;
	logic               sticky_new;

	assign sum        = {term[63], term} + {run_q[63], run_q};
	assign sum_ov     = sum[64] ^ sum[63];
	assign sum_sat    = sum_ov ? (sum[64] ? 64'sh8000000000000000 : 64'sh7fffffffffffffff)
		: sum[63:0];
	assign sticky_new = sticky_q | term_ov | sum_ov;

	// a last term needs the output register free (or freeing this cycle)
	assign acc_ready = !last || !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q       <= '0;
			sticky_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (add_en && acc_ready) begin
				if (last) begin
					run_q       <= '0;
					sticky_q    <= 1'b0;
					out_valid_q <= 1'b1;
				end else begin
					run_q    <= sum_sat;
					sticky_q <= sticky_new;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (add_en && acc_ready && last) begin
			sum_out_q <= sum_sat;
			ov_out_q  <= sticky_new;
		end
	end

	assign out_valid  = out_valid_q;
	assign series_sum = sum_out_q;
	assign overflowed = ov_out_q;

endmodule

### hdl/basis_series_evaluator.sv
// ----------------------------------------------------------------------------
// Basis series evaluator
// Evaluates a weighted series of power or Chebyshev basis terms (or their
// derivatives) in fixed point. Each accepted word is one term: its argument is
// normalized as (arg_x - arg_offset) * inv_scale in Q16.16, the basis selected
// by basis_select is evaluated at that point, weighted by the coefficient and
// added into a saturating Q32.32 sum that is emitted on the last term along
// with a sticky overflow flag. All multiplies run on one shared multiplier
// under a small sequencer, so the block takes one term at a time. Each term
// is normalized, set up, run through its basis recurrence, scaled by the
// order when a derivative basis needs it (every derivative term except order
// zero and the Chebyshev derivative of order one away from the endpoints),
// weighted and accumulated. The recurrence has L multiply steps: n for the
// power basis, n-1 for its derivative and for Chebyshev T_n, n-2 for the
// Chebyshev derivative (zero for trivial orders and endpoints). Each
// recurrence step is a multiply state and a round/saturate state through
// the shared multiplier, so a power term of order 31, or its derivative, is
// the worst case. A finished sum waits in an output register, so new terms
// are taken while it is pending; only the last term of the following series
// stalls until that word has been taken.
// ----------------------------------------------------------------------------
`include "basis_series_evaluator_defines.svh"

module basis_series_evaluator
	import bse_pkg::*;
#(
	parameter int MAX_ORDER = BSE_MAX_ORDER
) (
	input  logic               clk,
	input  logic               arst_n,
	// configuration
	input  logic               cfg_wr_en,
	input  logic [1:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	// term input
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [31:0] arg_x,
	input  logic [4:0]         term_order,
	input  logic signed [31:0] coefficient,
	input  logic               last_term,
	// series result
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [63:0] series_sum,
	output logic               overflowed
);

	// configuration registers
	logic signed [31:0] arg_offset_q;
	logic signed [31:0] inv_scale_q;
	basis_t             basis_select_q;

	// sequencer
	state_t state_q;
	state_t state_d;

	// per-term working registers
	logic signed [31:0] x_in_q;
	logic signed [31:0] coef_q;
	logic               last_q;
	logic [4:0]         n_q;
	logic [4:0]         k_q;     // recurrence steps left
	logic               ov_q;    // saturation seen in this term
	logic signed [31:0] xn_q;    // normalized argument
	logic signed [31:0] x_op_q;  // argument used in the loop (clipped for Chebyshev)
	logic signed [31:0] cur_q;   // current basis value
	logic signed [31:0] prev_q;  // previous basis value (Chebyshev)

	// shared multiplier
	logic               mul_load;
	logic signed [32:0] mul_a;
	logic signed [31:0] mul_b;
	mul_res_t           mul_res;

	// accumulator handshake
	logic acc_en;
	logic acc_ready;

	logic [4:0] n_clamp;

	// setup plan, worked out from the normalized argument
	logic signed [31:0] xc;
	logic signed [31:0] su_xop;
	logic signed [31:0] su_cur;
	logic signed [31:0] su_prev;
	logic [4:0]         su_k;
	state_t             su_next;

	// Chebyshev step 2*p - prev
	logic signed [64:0] cheb_diff;
	sat32_t             cheb_sat;

	logic is_cheb;
	logic is_der;

	assign is_cheb = (basis_select_q == BASIS_CHEB) || (basis_select_q == BASIS_CHEB_DER);
	assign is_der  = (basis_select_q == BASIS_POWER_DER) || (basis_select_q == BASIS_CHEB_DER);

	// clamp orders above the supported maximum
	assign n_clamp = (int'(term_order) > MAX_ORDER) ? 5'(MAX_ORDER) : term_order;

	// ------------------------------------------------------------------
	// Configuration writes; unknown indexes are dropped
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			arg_offset_q   <= '0;
			inv_scale_q    <= ONE_Q16;
			basis_select_q <= BASIS_POWER;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_ARG_OFFSET:   arg_offset_q   <= cfg_data;
				CFG_INV_SCALE:    inv_scale_q    <= cfg_data;
				CFG_BASIS_SELECT: basis_select_q <= basis_t'(cfg_data[1:0]);
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Setup plan: pick the loop start values and first state per basis
	// ------------------------------------------------------------------
	always_comb begin
		// clip to [-1, 1] for the Chebyshev bases
		if (xn_q > ONE_Q16) begin
			xc = ONE_Q16;
		end else if (xn_q < NEG_ONE_Q16) begin
			xc = NEG_ONE_Q16;
		end else begin
			xc = xn_q;
		end

		su_xop  = xn_q;
		su_cur  = ONE_Q16;
		su_prev = ONE_Q16;
		su_k    = n_q;
		su_next = ST_TERM_MUL;

		case (basis_select_q)
			BASIS_POWER: begin
				// x^0 is 1.0, otherwise multiply n times
				su_next = (n_q == '0) ? ST_TERM_MUL : ST_LOOP_MUL;
			end
			BASIS_POWER_DER: begin
				su_k = n_q - 5'd1;
				if (n_q == '0) begin
					su_cur  = '0;
					su_next = ST_TERM_MUL;
				end else if (n_q == 5'd1) begin
					su_next = ST_SCALE_MUL;
				end else begin
					su_next = ST_LOOP_MUL;
				end
			end
			BASIS_CHEB: begin
				su_xop = xc;
				su_k   = n_q - 5'd1;
				if (n_q == '0) begin
					su_next = ST_TERM_MUL;
				end else begin
					su_cur  = xc;
					su_next = (n_q == 5'd1) ? ST_TERM_MUL : ST_LOOP_MUL;
				end
			end
			BASIS_CHEB_DER: begin
				su_xop = xc;
				su_k   = n_q - 5'd2;
				if (n_q == '0) begin
					su_cur  = '0;
					su_next = ST_TERM_MUL;
				end else if ((xc == ONE_Q16) || (xc == NEG_ONE_Q16)) begin
					// endpoint: n*n, formed as (n << 16) * n
					su_cur  = 32'(n_q) <<< 16;
					su_next = ST_SCALE_MUL;
				end else if (n_q == 5'd1) begin
					su_next = ST_TERM_MUL;
				end else begin
					// U_1 = 2x, cannot overflow after clipping
					su_cur  = xc <<< 1;
					su_next = (n_q == 5'd2) ? ST_SCALE_MUL : ST_LOOP_MUL;
				end
			end
			default: ;
		endcase
	end

	// ------------------------------------------------------------------
	// Next state
	// ------------------------------------------------------------------
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:      if (in_valid) state_d = ST_NORM_MUL;
			ST_NORM_MUL:  state_d = ST_NORM_RND;
			ST_NORM_RND:  state_d = ST_SETUP;
			ST_SETUP:     state_d = su_next;
			ST_LOOP_MUL:  state_d = ST_LOOP_RND;
			ST_LOOP_RND: begin
				if (k_q == 5'd1) begin
					state_d = is_der ? ST_SCALE_MUL : ST_TERM_MUL;
				end else begin
					state_d = ST_LOOP_MUL;
				end
			end
			ST_SCALE_MUL: state_d = ST_SCALE_RND;
			ST_SCALE_RND: state_d = ST_TERM_MUL;
			ST_TERM_MUL:  state_d = ST_ACC;
			ST_ACC:       if (acc_ready) state_d = ST_IDLE;
			default:      state_d = ST_IDLE;
		endcase
	end

	// ------------------------------------------------------------------
	// Sequencer outputs: handshake and multiplier operand selection
	// ------------------------------------------------------------------
	always_comb begin
		in_ready = 1'b0;
		mul_load = 1'b0;
		acc_en   = 1'b0;
		mul_a    = {cur_q[31], cur_q};
		mul_b    = x_op_q;
		case (state_q)
			ST_IDLE: in_ready = 1'b1;
			ST_NORM_MUL: begin
				// 33-bit difference times the reciprocal scale
				mul_load = 1'b1;
				mul_a    = {x_in_q[31], x_in_q} - {arg_offset_q[31], arg_offset_q};
				mul_b    = inv_scale_q;
			end
			ST_LOOP_MUL: mul_load = 1'b1;
			ST_SCALE_MUL: begin
				mul_load = 1'b1;
				mul_b    = {27'b0, n_q};
			end
			ST_TERM_MUL: begin
				mul_load = 1'b1;
				mul_b    = coef_q;
			end
			ST_ACC: acc_en = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Chebyshev step: double the rounded product and subtract the older value
	assign cheb_diff = {{32{mul_res.rnd.val[31]}}, mul_res.rnd.val, 1'b0}
		- {{33{prev_q[31]}}, prev_q};
	assign cheb_sat  = sat32(cheb_diff);

	// ------------------------------------------------------------------
	// Working registers
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					x_in_q <= arg_x;
					coef_q <= coefficient;
					last_q <= last_term;
					n_q    <= n_clamp;
					ov_q   <= 1'b0;
				end
			end
			ST_NORM_RND: begin
				xn_q <= mul_res.rnd.val;
				ov_q <= ov_q | mul_res.rnd.ov;
			end
			ST_SETUP: begin
				x_op_q <= su_xop;
				cur_q  <= su_cur;
				prev_q <= su_prev;
				k_q    <= su_k;
			end
			ST_LOOP_RND: begin
				k_q <= k_q - 5'd1;
				if (is_cheb) begin
					cur_q  <= cheb_sat.val;
					prev_q <= cur_q;
					ov_q   <= ov_q | mul_res.rnd.ov | cheb_sat.ov;
				end else begin
					cur_q <= mul_res.rnd.val;
					ov_q  <= ov_q | mul_res.rnd.ov;
				end
			end
			ST_SCALE_RND: begin
				// integer order scaling is exact, then saturated
				cur_q <= mul_res.ext.val;
				ov_q  <= ov_q | mul_res.ext.ov;
			end
			default: ;
		endcase
	end

	bse_mul_unit u_mul (
		.clk  (clk),
		.load (mul_load),
		.op_a (mul_a),
		.op_b (mul_b),
		.res  (mul_res)
	);

	// the Q32.32 term is the exact product of basis value and coefficient
	bse_accum u_accum (
		.clk        (clk),
		.arst_n     (arst_n),
		.add_en     (acc_en),
		.term       (mul_res.full),
		.term_ov    (ov_q),
		.last       (last_q),
		.acc_ready  (acc_ready),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.series_sum (series_sum),
		.overflowed (overflowed)
	);

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	`BSE_ASSERT_NEXT(a_accept_starts_norm, in_valid && in_ready, state_q == ST_NORM_MUL)
	`BSE_ASSERT_SAME(a_loop_has_steps, state_q == ST_LOOP_MUL, k_q != 5'd0)
	`BSE_ASSERT_SAME(a_cheb_arg_clipped, (state_q == ST_LOOP_MUL) && is_cheb, (x_op_q <= ONE_Q16) && (x_op_q >= NEG_ONE_Q16))
	`BSE_ASSERT_NEXT(a_mid_term_no_stall, (state_q == ST_ACC) && !last_q, state_q == ST_IDLE)
	`BSE_ASSERT_SAME(a_result_from_last, $rose(out_valid), $past(state_q == ST_ACC) && $past(last_q))

endmodule
